>>> sv/cltok_pkg.sv
// Shared types, token codes and lookup functions for the C-style tokenizer.
// Depends on nothing; used by cltok_step and c_like_source_tokenizer_core.
package cltok_pkg;

    localparam int MAX_TOKEN_CHARS  = 64;
    localparam int MAX_STRING_CHARS = 256;
    localparam int LINE_BITS        = 24;
    localparam int COL_BITS         = 16;
    localparam int LEN_BITS         = 9;
    localparam int NUM_REC          = 3;
    localparam int QUEUE_DEPTH      = 8;
    localparam int QPTR_BITS        = 3;

    localparam logic [62:0] INT_CAP = {63{1'b1}};
    localparam logic [LINE_BITS-1:0] LINE_CAP = {LINE_BITS{1'b1}};
    localparam logic [COL_BITS-1:0] COL_CAP = {COL_BITS{1'b1}};
    localparam logic [LEN_BITS-1:0] TOK_LIMIT = LEN_BITS'(MAX_TOKEN_CHARS - 1);
    localparam logic [LEN_BITS-1:0] STR_LIMIT = LEN_BITS'(MAX_STRING_CHARS - 1);

    localparam logic [6:0] K_END     = 7'd0;
    localparam logic [6:0] K_SHL     = 7'd39;
    localparam logic [6:0] K_SHL_SET = 7'd40;
    localparam logic [6:0] K_SHR     = 7'd43;
    localparam logic [6:0] K_SHR_SET = 7'd44;
    localparam logic [6:0] K_INT     = 7'd83;
    localparam logic [6:0] K_FLOAT   = 7'd84;
    localparam logic [6:0] K_STRING  = 7'd85;
    localparam logic [6:0] K_CHAR    = 7'd86;
    localparam logic [6:0] K_IDENT   = 7'd87;
    localparam logic [6:0] K_PIECE   = 7'd88;
    localparam logic [6:0] K_ERROR   = 7'd89;

    localparam logic [1:0] R_DEC = 2'd0;
    localparam logic [1:0] R_HEX = 2'd1;
    localparam logic [1:0] R_BIN = 2'd2;

    typedef enum logic [10:0] {
        M_IDLE       = 11'b000_0000_0001,
        M_OP1        = 11'b000_0000_0010,
        M_OP2        = 11'b000_0000_0100,
        M_LINE       = 11'b000_0000_1000,
        M_BLOCK      = 11'b000_0001_0000,
        M_BLOCK_STAR = 11'b000_0010_0000,
        M_ZERO       = 11'b000_0100_0000,
        M_NUMBER     = 11'b000_1000_0000,
        M_SUFFIX     = 11'b001_0000_0000,
        M_IDENT      = 11'b010_0000_0000,
        M_STRING     = 11'b100_0000_0000
    } t_mode;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_source;
    } t_in_item;

    typedef struct packed {
        logic [6:0]           token_kind;
        logic [7:0]           text_byte;
        logic [62:0]          integer_value;
        logic [LINE_BITS-1:0] start_line;
        logic [COL_BITS-1:0]  start_column;
        logic                 last_of_run;
    } t_out_item;

    typedef struct packed {
        t_mode                mode;
        logic [7:0]           pend;
        logic [63:0]          word;
        logic [LEN_BITS-1:0]  tlen;
        logic [62:0]          acc;
        logic [1:0]           radix;
        logic                 flt;
        logic                 sq;
        logic                 esc;
        logic [LINE_BITS-1:0] line;
        logic [COL_BITS-1:0]  col;
        logic [LINE_BITS-1:0] tline;
        logic [COL_BITS-1:0]  tcol;
        logic                 err;
    } t_state;

    localparam logic [63:0] KW_WORD [49] = '{
        64'("if"), 64'("else"), 64'("while"), 64'("for"), 64'("do"), 64'("switch"),
        64'("case"), 64'("default"), 64'("break"), 64'("continue"), 64'("return"),
        64'("goto"),
        64'("I0"), 64'("I8"), 64'("I16"), 64'("I32"), 64'("I64"), 64'("U0"),
        64'("U8"), 64'("U16"), 64'("U32"), 64'("U64"), 64'("F64"), 64'("Bool"),
        64'("void"), 64'("char"), 64'("signed"), 64'("short"), 64'("int"),
        64'("long"), 64'("unsigned"), 64'("short"), 64'("char"), 64'("float"),
        64'("double"), 64'("bool"), 64'("auto"),
        64'("class"), 64'("struct"), 64'("union"), 64'("typedef"), 64'("enum"),
        64'("static"), 64'("extern"), 64'("public"), 64'("const"), 64'("volatile"),
        64'("inline"), 64'("sizeof")
    };

    localparam logic [6:0] KW_KIND [49] = '{
        7'd46, 7'd47, 7'd48, 7'd49, 7'd50, 7'd51, 7'd52, 7'd53, 7'd54, 7'd55, 7'd56,
        7'd57,
        7'd58, 7'd59, 7'd60, 7'd61, 7'd62, 7'd63, 7'd64, 7'd65, 7'd66, 7'd67, 7'd68,
        7'd69,
        7'd63, 7'd59, 7'd61, 7'd60, 7'd61, 7'd62, 7'd66, 7'd60, 7'd64, 7'd68, 7'd68,
        7'd69, 7'd70,
        7'd71, 7'd72, 7'd73, 7'd74, 7'd75,
        7'd76, 7'd77, 7'd78, 7'd79, 7'd80, 7'd81, 7'd82
    };

    // The word holds the collected characters right-aligned, like a string literal.
    function automatic logic [6:0] kw_kind(input logic [LEN_BITS-1:0] len,
                                           input logic [63:0] word);
        logic [6:0] k;
        k = K_IDENT;
        if (len <= LEN_BITS'(8)) begin
            for (int i = 48; i >= 0; i--) begin
                if (word == KW_WORD[i]) begin
                    k = KW_KIND[i];
                end
            end
        end
        return k;
    endfunction

    function automatic logic [6:0] op_plain(input logic [7:0] ch);
        case (ch)
            "(": return 7'd1;
            ")": return 7'd2;
            "{": return 7'd3;
            "}": return 7'd4;
            "[": return 7'd5;
            "]": return 7'd6;
            ",": return 7'd7;
            ";": return 7'd8;
            ":": return 7'd9;
            "?": return 7'd10;
            ".": return 7'd11;
            "~": return 7'd12;
            default: return 7'd0;
        endcase
    endfunction

    function automatic logic [6:0] op_single(input logic [7:0] p);
        case (p)
            "+": return 7'd13;
            "-": return 7'd16;
            "*": return 7'd20;
            "/": return 7'd22;
            "%": return 7'd24;
            "&": return 7'd26;
            "|": return 7'd29;
            "^": return 7'd32;
            "!": return 7'd34;
            "=": return 7'd36;
            "<": return 7'd38;
            ">": return 7'd42;
            default: return 7'd0;
        endcase
    endfunction

    function automatic logic [6:0] op_pair(input logic [7:0] p, input logic [7:0] ch);
        logic eq;
        eq = (ch == "=");
        case (p)
            "+": return (ch == "+") ? 7'd14 : eq ? 7'd15 : 7'd0;
            "-": return (ch == "-") ? 7'd17 : eq ? 7'd18 : (ch == ">") ? 7'd19 : 7'd0;
            "*": return eq ? 7'd21 : 7'd0;
            "/": return eq ? 7'd23 : 7'd0;
            "%": return eq ? 7'd25 : 7'd0;
            "&": return (ch == "&") ? 7'd27 : eq ? 7'd28 : 7'd0;
            "|": return (ch == "|") ? 7'd30 : eq ? 7'd31 : 7'd0;
            "^": return eq ? 7'd33 : 7'd0;
            "!": return eq ? 7'd35 : 7'd0;
            "=": return eq ? 7'd37 : 7'd0;
            "<": return eq ? 7'd41 : 7'd0;
            ">": return eq ? 7'd45 : 7'd0;
            default: return 7'd0;
        endcase
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return (ch >= "0") && (ch <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] ch);
        return ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));
    endfunction

    function automatic logic [4:0] hex_val(input logic [7:0] ch);
        logic [7:0] d;
        d = 8'd16;
        if (is_digit(ch)) begin
            d = ch - 8'h30;
        end else if ((ch >= "a") && (ch <= "f")) begin
            d = ch - 8'h57;
        end else if ((ch >= "A") && (ch <= "F")) begin
            d = ch - 8'h37;
        end
        return d[4:0];
    endfunction

endpackage

>>> sv/cltok_step.sv
// Next-state and record logic of the tokenizer for one source byte or end mark.
// Depends on cltok_pkg; purely combinational, instanced by the top level.
module cltok_step (
    input  cltok_pkg::t_state                     i_state,
    input  cltok_pkg::t_in_item                   i_item,
    output cltok_pkg::t_state                     o_state,
    output cltok_pkg::t_out_item [2:0]            o_rec,
    output logic [1:0]                            o_count
);
    import cltok_pkg::*;

    always_comb begin
        t_state     s;
        t_out_item  rec [NUM_REC];
        logic [1:0] n;
        logic [7:0] ch;
        logic       go;
        logic       e_v;
        logic       e_here;
        logic [6:0] e_kind;
        logic [7:0] e_byte;
        logic [62:0] e_val;
        logic [6:0] k;
        logic       take;
        logic [4:0] dig;
        logic [66:0] prod;
        logic [66:0] sum;

        s = i_state;
        n = 2'd0;
        ch = i_item.char_byte;
        go = 1'b0;
        e_v = 1'b0;
        e_here = 1'b0;
        e_kind = 7'd0;
        e_byte = 8'd0;
        e_val = '0;
        k = 7'd0;
        take = 1'b0;
        dig = 5'd0;
        prod = '0;
        sum = '0;
        for (int r = 0; r < NUM_REC; r++) begin
            rec[r] = '0;
        end

        if (i_item.end_of_source) begin
            e_v = 1'b1;
            e_kind = K_END;
            e_val = '0;
            case (s.mode)
                M_OP1:    e_kind = op_single(s.pend);
                M_OP2:    e_kind = (s.pend == "<") ? K_SHL : K_SHR;
                M_ZERO:   e_kind = K_INT;
                M_NUMBER: begin
                    e_kind = s.flt ? K_FLOAT : K_INT;
                    e_val = s.flt ? 63'd0 : s.acc;
                end
                M_SUFFIX: begin
                    e_kind = K_INT;
                    e_val = s.acc;
                end
                M_IDENT:  e_kind = kw_kind(s.tlen, s.word);
                M_STRING: e_kind = s.sq ? K_CHAR : K_STRING;
                default:  e_v = 1'b0;
            endcase
            if (e_v) begin
                rec[0].token_kind = e_kind;
                rec[0].integer_value = e_val;
                rec[0].start_line = s.tline;
                rec[0].start_column = s.tcol;
                n = 2'd1;
            end
            rec[n].token_kind = K_END;
            rec[n].start_line = s.line;
            rec[n].start_column = s.col;
            n = n + 2'd1;
            s.mode = M_IDLE;
            s.esc = 1'b0;
        end else if (!s.err) begin
            go = 1'b1;
            for (int it = 0; it < 4; it++) begin
                e_v = 1'b0;
                e_here = 1'b0;
                e_kind = 7'd0;
                e_byte = 8'd0;
                e_val = '0;
                if (go) begin
                    go = 1'b0;
                    case (s.mode)
                        M_IDLE: begin
                            s.tline = s.line;
                            s.tcol = s.col;
                            if (ch == " " || ch == 8'h09 || ch == 8'h0D || ch == 8'h0A) begin
                                e_v = 1'b0;
                            end else if (op_plain(ch) != 7'd0) begin
                                e_v = 1'b1;
                                e_kind = op_plain(ch);
                            end else if (op_single(ch) != 7'd0) begin
                                s.pend = ch;
                                s.mode = M_OP1;
                            end else if (ch == 8'h22 || ch == 8'h27) begin
                                s.sq = (ch == 8'h27);
                                s.tlen = '0;
                                s.mode = M_STRING;
                            end else if (is_digit(ch)) begin
                                s.radix = R_DEC;
                                s.flt = 1'b0;
                                if (ch == "0") begin
                                    s.acc = '0;
                                    s.tlen = '0;
                                    s.mode = M_ZERO;
                                end else begin
                                    s.acc = 63'(ch - 8'h30);
                                    s.tlen = LEN_BITS'(1);
                                    e_v = 1'b1;
                                    e_kind = K_PIECE;
                                    e_byte = ch;
                                    s.mode = M_NUMBER;
                                end
                            end else if (is_alpha(ch) || ch == "_") begin
                                s.word = 64'(ch);
                                s.tlen = LEN_BITS'(1);
                                e_v = 1'b1;
                                e_kind = K_PIECE;
                                e_byte = ch;
                                s.mode = M_IDENT;
                            end else begin
                                e_v = 1'b1;
                                e_here = 1'b1;
                                e_kind = K_ERROR;
                                s.err = 1'b1;
                            end
                        end
                        M_OP1: begin
                            if (s.pend == "/" && ch == "/") begin
                                s.mode = M_LINE;
                            end else if (s.pend == "/" && ch == "*") begin
                                s.mode = M_BLOCK;
                            end else if ((s.pend == "<" || s.pend == ">") && ch == s.pend) begin
                                s.mode = M_OP2;
                            end else begin
                                k = op_pair(s.pend, ch);
                                s.mode = M_IDLE;
                                e_v = 1'b1;
                                if (k != 7'd0) begin
                                    e_kind = k;
                                end else begin
                                    e_kind = op_single(s.pend);
                                    go = 1'b1;
                                end
                            end
                        end
                        M_OP2: begin
                            s.mode = M_IDLE;
                            e_v = 1'b1;
                            if (ch == "=") begin
                                e_kind = (s.pend == "<") ? K_SHL_SET : K_SHR_SET;
                            end else begin
                                e_kind = (s.pend == "<") ? K_SHL : K_SHR;
                                go = 1'b1;
                            end
                        end
                        M_LINE: begin
                            if (ch == 8'h0A) begin
                                s.mode = M_IDLE;
                            end
                        end
                        M_BLOCK: begin
                            if (ch == "*") begin
                                s.mode = M_BLOCK_STAR;
                            end
                        end
                        M_BLOCK_STAR: begin
                            if (ch == "/") begin
                                s.mode = M_IDLE;
                            end else if (ch != "*") begin
                                s.mode = M_BLOCK;
                            end
                        end
                        M_ZERO: begin
                            s.mode = M_NUMBER;
                            if (ch == "x" || ch == "X") begin
                                s.radix = R_HEX;
                            end else if (ch == "b" || ch == "B") begin
                                s.radix = R_BIN;
                            end else begin
                                s.radix = R_DEC;
                                go = 1'b1;
                            end
                        end
                        M_NUMBER: begin
                            dig = hex_val(ch);
                            if (s.radix == R_HEX) begin
                                take = (dig < 5'd16);
                                prod = {s.acc, 4'b0};
                            end else if (s.radix == R_BIN) begin
                                take = (ch == "0" || ch == "1");
                                prod = {3'b0, s.acc, 1'b0};
                            end else begin
                                take = is_digit(ch);
                                prod = {1'b0, s.acc, 3'b0} + {3'b0, s.acc, 1'b0};
                            end
                            sum = prod + 67'(dig);
                            if (s.tlen < TOK_LIMIT && take) begin
                                if (s.radix != R_DEC || !s.flt) begin
                                    s.acc = (sum > 67'(INT_CAP)) ? INT_CAP : sum[62:0];
                                end
                                s.tlen = s.tlen + LEN_BITS'(1);
                                e_v = 1'b1;
                                e_kind = K_PIECE;
                                e_byte = ch;
                            end else if (s.tlen < TOK_LIMIT && s.radix == R_DEC && !s.flt
                                         && ch == ".") begin
                                s.flt = 1'b1;
                                s.tlen = s.tlen + LEN_BITS'(1);
                                e_v = 1'b1;
                                e_kind = K_PIECE;
                                e_byte = ch;
                            end else if (s.flt) begin
                                e_v = 1'b1;
                                e_kind = K_FLOAT;
                                s.mode = M_IDLE;
                                go = 1'b1;
                            end else begin
                                s.mode = M_SUFFIX;
                                go = 1'b1;
                            end
                        end
                        M_SUFFIX: begin
                            if (!(ch == "L" || ch == "l" || ch == "U" || ch == "u")) begin
                                e_v = 1'b1;
                                e_kind = K_INT;
                                e_val = s.acc;
                                s.mode = M_IDLE;
                                go = 1'b1;
                            end
                        end
                        M_IDENT: begin
                            if (s.tlen < TOK_LIMIT && (is_alpha(ch) || is_digit(ch) || ch == "_"))
                            begin
                                if (s.tlen < LEN_BITS'(8)) begin
                                    s.word = {s.word[55:0], ch};
                                end
                                s.tlen = s.tlen + LEN_BITS'(1);
                                e_v = 1'b1;
                                e_kind = K_PIECE;
                                e_byte = ch;
                            end else begin
                                e_v = 1'b1;
                                e_kind = kw_kind(s.tlen, s.word);
                                s.mode = M_IDLE;
                                go = 1'b1;
                            end
                        end
                        M_STRING: begin
                            k = s.sq ? K_CHAR : K_STRING;
                            if (s.esc) begin
                                e_byte = ch;
                                case (ch)
                                    "n":     e_byte = 8'd10;
                                    "t":     e_byte = 8'd9;
                                    "r":     e_byte = 8'd13;
                                    "0":     e_byte = 8'd0;
                                    default: e_byte = ch;
                                endcase
                                e_v = 1'b1;
                                e_kind = K_PIECE;
                                s.tlen = s.tlen + LEN_BITS'(1);
                                s.esc = 1'b0;
                            end else if (s.tlen >= STR_LIMIT) begin
                                e_v = 1'b1;
                                e_kind = k;
                                s.mode = M_IDLE;
                                go = 1'b1;
                            end else if (ch == (s.sq ? 8'h27 : 8'h22)) begin
                                e_v = 1'b1;
                                e_kind = k;
                                s.mode = M_IDLE;
                            end else if (ch == 8'h5C) begin
                                s.esc = 1'b1;
                            end else begin
                                e_v = 1'b1;
                                e_kind = K_PIECE;
                                e_byte = ch;
                                s.tlen = s.tlen + LEN_BITS'(1);
                            end
                        end
                        default: begin
                            s.mode = M_IDLE;
                            go = 1'b1;
                        end
                    endcase
                end
                if (e_v && n < 2'd3) begin
                    rec[n].token_kind = e_kind;
                    rec[n].text_byte = e_byte;
                    rec[n].integer_value = e_val;
                    rec[n].start_line = e_here ? s.line : s.tline;
                    rec[n].start_column = e_here ? s.col : s.tcol;
                    n = n + 2'd1;
                end
            end
            if (ch == 8'h0A) begin
                if (s.line != LINE_CAP) begin
                    s.line = s.line + LINE_BITS'(1);
                end
                s.col = COL_BITS'(1);
            end else if (s.col != COL_CAP) begin
                s.col = s.col + COL_BITS'(1);
            end
        end

        if (n != 2'd0) begin
            rec[n - 2'd1].last_of_run = 1'b1;
        end
        o_state = s;
        o_count = n;
        for (int r = 0; r < NUM_REC; r++) begin
            o_rec[r] = rec[r];
        end
    end

endmodule

>>> sv/c_like_source_tokenizer_core.sv
// Top level of the C-style tokenizer: scan state registers and result queue.
// Depends on cltok_pkg and cltok_step.
//
// Usage: source bytes enter on the input channel (i_in_valid, o_in_stall,
// i_in_item); an item with end_of_source set flushes the pending token and
// yields an end token. Tokens and text pieces leave on the output channel
// (o_out_valid, i_out_stall, o_out_item), one record per item, with
// last_of_run marking the final record caused by one input item.
// Each input item is scanned in the cycle it is accepted and its zero to three
// records are written into an eight-entry queue; with the queue empty, the first
// record is visible in the cycle after acceptance. One input item is accepted
// every cycle while the queue holds five or fewer records, so the rate is one
// item per cycle as long as the receiver drains at least as fast as records
// are produced. When the receiver stalls, the queue fills and o_in_stall rises;
// nothing is dropped. Reset empties the queue, sets the position to line 1,
// column 1, and returns the scanner to idle with the error flag cleared.
module c_like_source_tokenizer_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  cltok_pkg::t_in_item    i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output cltok_pkg::t_out_item   o_out_item
);
    import cltok_pkg::*;

    t_state                r_state;
    t_state                n_state;
    t_out_item [2:0]       step_rec;
    logic [1:0]            step_cnt;
    t_out_item             r_q [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  r_wp;
    logic [QPTR_BITS-1:0]  r_rp;
    logic [QPTR_BITS:0]    r_cnt;
    logic                  in_acc;
    logic                  out_acc;

    cltok_step u_step (
        .i_state (r_state),
        .i_item  (i_in_item),
        .o_state (n_state),
        .o_rec   (step_rec),
        .o_count (step_cnt)
    );

    assign o_in_stall  = (r_cnt > (QPTR_BITS+1)'(QUEUE_DEPTH - NUM_REC));
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_cnt != '0);
    assign out_acc     = o_out_valid && !i_out_stall;
    assign o_out_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{mode: M_IDLE, radix: R_DEC, line: LINE_BITS'(1),
                         col: COL_BITS'(1), default: '0};
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (in_acc) begin
                r_state <= n_state;
                r_wp <= r_wp + QPTR_BITS'(step_cnt);
            end
            if (out_acc) begin
                r_rp <= r_rp + QPTR_BITS'(1);
            end
            r_cnt <= r_cnt + (in_acc ? (QPTR_BITS+1)'(step_cnt) : '0)
                     - (out_acc ? (QPTR_BITS+1)'(1) : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int r = 0; r < NUM_REC; r++) begin
                if (2'(r) < step_cnt) begin
                    r_q[r_wp + QPTR_BITS'(r)] <= step_rec[r];
                end
            end
        end
    end

`ifndef SYNTH
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QPTR_BITS+1)'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_queue_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wp - r_rp) == r_cnt[QPTR_BITS-1:0])
        else $error("queue pointers disagree with count");

    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.line != '0 && r_state.col != '0)
        else $error("position counter reached zero");
`endif

endmodule

>>> sim/c_like_source_tokenizer_core_test.sv
// Self-checking testbench for c_like_source_tokenizer_core: source bytes go in, and token
// and text piece records are checked against a scanner model kept in this file.
// Depends on cltok_pkg and the tokenizer RTL.
`timescale 1ns / 1ps

module c_like_source_tokenizer_core_test;

    import cltok_pkg::*;

    localparam int IDLE_LIMIT = 1000;
    localparam int RANDOM_ITEMS = 200;

    typedef enum logic [6:0] {
        OP_LPAREN = 7'd1, OP_RPAREN, OP_LBRACE, OP_RBRACE, OP_LBRACK, OP_RBRACK, OP_COMMA,
        OP_SEMI, OP_COLON, OP_QUEST, OP_DOT, OP_TILDE,
        OP_PLUS, OP_INC, OP_ADD_SET, OP_MINUS, OP_DEC, OP_SUB_SET, OP_ARROW,
        OP_STAR, OP_MUL_SET, OP_SLASH, OP_DIV_SET, OP_PCT, OP_MOD_SET,
        OP_AMP, OP_LAND, OP_AND_SET, OP_BAR, OP_LOR, OP_OR_SET, OP_CARET, OP_XOR_SET,
        OP_BANG, OP_NE, OP_ASSIGN, OP_EQ, OP_LT, OP_SHL, OP_SHL_SET, OP_LE,
        OP_GT, OP_SHR, OP_SHR_SET, OP_GE
    } t_op_kind;

    typedef enum logic [6:0] {
        KW_IF = 7'd46, KW_ELSE, KW_WHILE, KW_FOR, KW_DO, KW_SWITCH, KW_CASE, KW_DEFAULT,
        KW_BREAK, KW_CONTINUE, KW_RETURN, KW_GOTO,
        KW_I0, KW_I8, KW_I16, KW_I32, KW_I64, KW_U0, KW_U8, KW_U16, KW_U32, KW_U64, KW_F64,
        KW_BOOL, KW_AUTO, KW_CLASS, KW_STRUCT, KW_UNION, KW_TYPEDEF, KW_ENUM,
        KW_STATIC, KW_EXTERN, KW_PUBLIC, KW_CONST, KW_VOLATILE, KW_INLINE, KW_SIZEOF
    } t_kw_kind;

    typedef enum {
        SC_IDLE, SC_OP1, SC_OP2, SC_LINE, SC_BLOCK, SC_BLOCK_STAR, SC_ZERO, SC_NUMBER,
        SC_SUFFIX, SC_IDENT, SC_STRING
    } t_scan;

    localparam string SINGLE_OPS = "(){}[],;:?.~";
    localparam string OP_CHARS = "(){}[],;:?.~+-*/%&|^!=<>";
    localparam string WORD_CHARS =
        "_abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
    localparam string HEX_CHARS = "0123456789abcdefABCDEF";
    localparam string ESC_CHARS = "ntr0\"'\\q";
    localparam string SPACE_CHARS = " \t\r\n";
    localparam string GAP_CHARS = " \n";

    string kw_text [49] = '{
        "if", "else", "while", "for", "do", "switch", "case", "default", "break",
        "continue", "return", "goto",
        "I0", "I8", "I16", "I32", "I64", "U0", "U8", "U16", "U32", "U64", "F64", "Bool",
        "void", "char", "signed", "short", "int", "long", "unsigned", "short", "char",
        "float", "double", "bool", "auto",
        "class", "struct", "union", "typedef", "enum",
        "static", "extern", "public", "const", "volatile", "inline", "sizeof"
    };
    t_kw_kind kw_code [49] = '{
        KW_IF, KW_ELSE, KW_WHILE, KW_FOR, KW_DO, KW_SWITCH, KW_CASE, KW_DEFAULT, KW_BREAK,
        KW_CONTINUE, KW_RETURN, KW_GOTO,
        KW_I0, KW_I8, KW_I16, KW_I32, KW_I64, KW_U0, KW_U8, KW_U16, KW_U32, KW_U64, KW_F64,
        KW_BOOL,
        KW_U0, KW_I8, KW_I32, KW_I16, KW_I32, KW_I64, KW_U32, KW_I16, KW_U8,
        KW_F64, KW_F64, KW_BOOL, KW_AUTO,
        KW_CLASS, KW_STRUCT, KW_UNION, KW_TYPEDEF, KW_ENUM,
        KW_STATIC, KW_EXTERN, KW_PUBLIC, KW_CONST, KW_VOLATILE, KW_INLINE, KW_SIZEOF
    };

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_item   i_in_item;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_item  o_out_item;

    c_like_source_tokenizer_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // Scanner model state.
    t_scan                mode;
    logic [7:0]           pend;
    string                word;
    int unsigned          tlen;
    logic [62:0]          acc;
    logic [1:0]           radix;
    bit                   float_seen;
    bit                   single_q;
    bit                   escaped;
    logic [LINE_BITS-1:0] line;
    logic [15:0]          col;
    logic [LINE_BITS-1:0] tline;
    logic [15:0]          tcol;
    bit                   err_seen;

    t_out_item step_recs[$];
    t_out_item tokens_due[$];
    int        mismatches;
    int        idle_cycles;
    int        items_sent;
    bit        steady_send;
    bit        steady_recv;
    int        recv_hold;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic bit digit_ch(input logic [7:0] ch);
        return ch >= "0" && ch <= "9";
    endfunction

    function automatic bit letter_ch(input logic [7:0] ch);
        return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
    endfunction

    function automatic int unsigned hex_digit(input logic [7:0] ch);
        if (digit_ch(ch)) return ch - "0";
        if (ch >= "a" && ch <= "f") return ch - "a" + 10;
        if (ch >= "A" && ch <= "F") return ch - "A" + 10;
        return 16;
    endfunction

    function automatic logic [6:0] lone_op(input logic [7:0] p);
        case (p)
            "+": return OP_PLUS;
            "-": return OP_MINUS;
            "*": return OP_STAR;
            "/": return OP_SLASH;
            "%": return OP_PCT;
            "&": return OP_AMP;
            "|": return OP_BAR;
            "^": return OP_CARET;
            "!": return OP_BANG;
            "=": return OP_ASSIGN;
            "<": return OP_LT;
            ">": return OP_GT;
            default: return K_END;
        endcase
    endfunction

    function automatic logic [6:0] paired_op(input logic [7:0] p, input logic [7:0] ch);
        case (p)
            "+": return ch == "+" ? OP_INC : ch == "=" ? OP_ADD_SET : K_END;
            "-": return ch == "-" ? OP_DEC : ch == "=" ? OP_SUB_SET :
                        ch == ">" ? OP_ARROW : K_END;
            "*": return ch == "=" ? OP_MUL_SET : K_END;
            "/": return ch == "=" ? OP_DIV_SET : K_END;
            "%": return ch == "=" ? OP_MOD_SET : K_END;
            "&": return ch == "&" ? OP_LAND : ch == "=" ? OP_AND_SET : K_END;
            "|": return ch == "|" ? OP_LOR : ch == "=" ? OP_OR_SET : K_END;
            "^": return ch == "=" ? OP_XOR_SET : K_END;
            "!": return ch == "=" ? OP_NE : K_END;
            "=": return ch == "=" ? OP_EQ : K_END;
            "<": return ch == "=" ? OP_LE : K_END;
            ">": return ch == "=" ? OP_GE : K_END;
            default: return K_END;
        endcase
    endfunction

    function automatic logic [6:0] word_kind();
        if (tlen > 8) return K_IDENT;
        foreach (kw_text[i]) begin
            if (kw_text[i] == word) return kw_code[i];
        end
        return K_IDENT;
    endfunction

    function automatic void add_rec(input logic [6:0] k, input logic [7:0] b,
                                    input logic [62:0] v, input logic [LINE_BITS-1:0] ln,
                                    input logic [15:0] cl);
        t_out_item r;
        if (step_recs.size() < NUM_REC) begin
            r.token_kind = k;
            r.text_byte = b;
            r.integer_value = v;
            r.start_line = ln;
            r.start_column = cl;
            r.last_of_run = 1'b0;
            step_recs.push_back(r);
        end
    endfunction

    function automatic void add_tok(input logic [6:0] k, input logic [7:0] b,
                                    input logic [62:0] v);
        add_rec(k, b, v, tline, tcol);
    endfunction

    function automatic void add_digit(input int unsigned d, input int unsigned base);
        logic [63:0] a;
        a = {1'b0, acc};
        if (a > ({1'b0, INT_CAP} - d) / base) acc = INT_CAP;
        else acc = 63'(a * base + d);
    endfunction

    function automatic void open_token(input logic [7:0] ch);
        string one;
        tline = line;
        tcol = col;
        if (ch == " " || ch == "\t" || ch == "\r" || ch == "\n") return;
        for (int i = 0; i < SINGLE_OPS.len(); i++) begin
            if (SINGLE_OPS[i] == ch) begin
                add_tok(OP_LPAREN + 7'(i), 8'd0, '0);
                return;
            end
        end
        if (lone_op(ch) != K_END) begin
            pend = ch;
            mode = SC_OP1;
            return;
        end
        if (ch == "\"" || ch == "'") begin
            single_q = (ch == "'");
            tlen = 0;
            mode = SC_STRING;
            return;
        end
        if (digit_ch(ch)) begin
            acc = '0;
            radix = R_DEC;
            float_seen = 1'b0;
            tlen = 0;
            if (ch == "0") begin
                mode = SC_ZERO;
                return;
            end
            acc = 63'(ch - "0");
            tlen = 1;
            add_tok(K_PIECE, ch, '0);
            mode = SC_NUMBER;
            return;
        end
        if (letter_ch(ch) || ch == "_") begin
            one = " ";
            one[0] = ch;
            word = one;
            tlen = 1;
            add_tok(K_PIECE, ch, '0);
            mode = SC_IDENT;
            return;
        end
        add_rec(K_ERROR, 8'd0, '0, line, col);
        err_seen = 1'b1;
    endfunction

    function automatic void scan_char(input logic [7:0] ch);
        logic [6:0] k;
        logic [7:0] d;
        bit take;
        string one;
        forever begin
            case (mode)
                SC_IDLE: begin
                    open_token(ch);
                    return;
                end
                SC_OP1: begin
                    if (pend == "/" && ch == "/") begin
                        mode = SC_LINE;
                        return;
                    end
                    if (pend == "/" && ch == "*") begin
                        mode = SC_BLOCK;
                        return;
                    end
                    if ((pend == "<" || pend == ">") && ch == pend) begin
                        mode = SC_OP2;
                        return;
                    end
                    k = paired_op(pend, ch);
                    mode = SC_IDLE;
                    if (k != K_END) begin
                        add_tok(k, 8'd0, '0);
                        return;
                    end
                    add_tok(lone_op(pend), 8'd0, '0);
                end
                SC_OP2: begin
                    mode = SC_IDLE;
                    if (ch == "=") begin
                        add_tok(pend == "<" ? K_SHL_SET : K_SHR_SET, 8'd0, '0);
                        return;
                    end
                    add_tok(pend == "<" ? K_SHL : K_SHR, 8'd0, '0);
                end
                SC_LINE: begin
                    if (ch == "\n") mode = SC_IDLE;
                    return;
                end
                SC_BLOCK: begin
                    if (ch == "*") mode = SC_BLOCK_STAR;
                    return;
                end
                SC_BLOCK_STAR: begin
                    if (ch == "/") mode = SC_IDLE;
                    else if (ch != "*") mode = SC_BLOCK;
                    return;
                end
                SC_ZERO: begin
                    mode = SC_NUMBER;
                    if (ch == "x" || ch == "X") begin
                        radix = R_HEX;
                        return;
                    end
                    if (ch == "b" || ch == "B") begin
                        radix = R_BIN;
                        return;
                    end
                    radix = R_DEC;
                end
                SC_NUMBER: begin
                    if (tlen < MAX_TOKEN_CHARS - 1) begin
                        if (radix == R_HEX) take = hex_digit(ch) < 16;
                        else if (radix == R_BIN) take = (ch == "0" || ch == "1");
                        else take = digit_ch(ch);
                        if (take) begin
                            if (radix == R_HEX) add_digit(hex_digit(ch), 16);
                            else if (radix == R_BIN) add_digit(ch - "0", 2);
                            else if (!float_seen) add_digit(ch - "0", 10);
                            tlen++;
                            add_tok(K_PIECE, ch, '0);
                            return;
                        end
                        if (radix == R_DEC && !float_seen && ch == ".") begin
                            float_seen = 1'b1;
                            tlen++;
                            add_tok(K_PIECE, ch, '0);
                            return;
                        end
                    end
                    if (float_seen) begin
                        add_tok(K_FLOAT, 8'd0, '0);
                        mode = SC_IDLE;
                    end else begin
                        mode = SC_SUFFIX;
                    end
                end
                SC_SUFFIX: begin
                    if (ch == "L" || ch == "l" || ch == "U" || ch == "u") return;
                    add_tok(K_INT, 8'd0, acc);
                    mode = SC_IDLE;
                end
                SC_IDENT: begin
                    if (tlen < MAX_TOKEN_CHARS - 1 &&
                        (letter_ch(ch) || digit_ch(ch) || ch == "_")) begin
                        if (tlen < 8) begin
                            one = " ";
                            one[0] = ch;
                            word = {word, one};
                        end
                        tlen++;
                        add_tok(K_PIECE, ch, '0);
                        return;
                    end
                    add_tok(word_kind(), 8'd0, '0);
                    mode = SC_IDLE;
                end
                default: begin
                    if (escaped) begin
                        d = ch;
                        if (ch == "n") d = 8'd10;
                        else if (ch == "t") d = 8'd9;
                        else if (ch == "r") d = 8'd13;
                        else if (ch == "0") d = 8'd0;
                        add_tok(K_PIECE, d, '0);
                        tlen++;
                        escaped = 1'b0;
                        return;
                    end
                    k = single_q ? K_CHAR : K_STRING;
                    if (tlen >= MAX_STRING_CHARS - 1) begin
                        add_tok(k, 8'd0, '0);
                        mode = SC_IDLE;
                    end else if (ch == (single_q ? 8'h27 : 8'h22)) begin
                        add_tok(k, 8'd0, '0);
                        mode = SC_IDLE;
                        return;
                    end else if (ch == "\\") begin
                        escaped = 1'b1;
                        return;
                    end else begin
                        add_tok(K_PIECE, ch, '0);
                        tlen++;
                        return;
                    end
                end
            endcase
        end
    endfunction

    function automatic void flush_token();
        case (mode)
            SC_OP1: add_tok(lone_op(pend), 8'd0, '0);
            SC_OP2: add_tok(pend == "<" ? K_SHL : K_SHR, 8'd0, '0);
            SC_ZERO: add_tok(K_INT, 8'd0, '0);
            SC_NUMBER: add_tok(float_seen ? K_FLOAT : K_INT, 8'd0, float_seen ? '0 : acc);
            SC_SUFFIX: add_tok(K_INT, 8'd0, acc);
            SC_IDENT: add_tok(word_kind(), 8'd0, '0);
            SC_STRING: add_tok(single_q ? K_CHAR : K_STRING, 8'd0, '0);
            default: ;
        endcase
        mode = SC_IDLE;
        escaped = 1'b0;
    endfunction

    function automatic void scan_item(input logic [7:0] ch, input bit eos);
        step_recs.delete();
        if (eos) begin
            flush_token();
            add_rec(K_END, 8'd0, '0, line, col);
        end else if (!err_seen) begin
            scan_char(ch);
            if (ch == "\n") begin
                if (line != LINE_CAP) line++;
                col = 16'd1;
            end else if (col != COL_CAP) begin
                col++;
            end
        end
        if (step_recs.size() > 0) step_recs[step_recs.size() - 1].last_of_run = 1'b1;
        foreach (step_recs[i]) tokens_due.push_back(step_recs[i]);
    endfunction

    task automatic send_item(input logic [7:0] ch, input bit eos);
        int gap;
        gap = steady_send ? 0 : $urandom_range(0, 18);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_item <= '{char_byte: ch, end_of_source: eos};
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        scan_item(ch, eos);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    endtask

    task automatic send_end();
        send_item(8'($urandom), 1'b1);
    endtask

    always @(posedge i_clk) begin
        int nxt;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            recv_hold = 0;
        end else begin
            nxt = recv_hold;
            if (o_out_valid && !i_out_stall) begin
                if (tokens_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected record: kind %0d",
                                                   o_out_item.token_kind);
                end else begin
                    if (o_out_item.token_kind !== tokens_due[0].token_kind ||
                        o_out_item.text_byte !== tokens_due[0].text_byte ||
                        o_out_item.integer_value !== tokens_due[0].integer_value ||
                        o_out_item.start_line !== tokens_due[0].start_line ||
                        o_out_item.start_column !== tokens_due[0].start_column ||
                        o_out_item.last_of_run !== tokens_due[0].last_of_run) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch exp kind %0d byte %h val %0d at %0d:%0d last %b",
                                     tokens_due[0].token_kind, tokens_due[0].text_byte,
                                     tokens_due[0].integer_value, tokens_due[0].start_line,
                                     tokens_due[0].start_column, tokens_due[0].last_of_run);
                            $display("         got kind %0d byte %h val %0d at %0d:%0d last %b",
                                     o_out_item.token_kind, o_out_item.text_byte,
                                     o_out_item.integer_value, o_out_item.start_line,
                                     o_out_item.start_column, o_out_item.last_of_run);
                        end
                    end
                    void'(tokens_due.pop_front());
                end
                if ($urandom_range(0, 99) == 0) steady_recv = !steady_recv;
                nxt = steady_recv ? 0 : $urandom_range(0, 18);
            end else if (nxt > 0) begin
                nxt--;
            end
            recv_hold = nxt;
            i_out_stall <= (nxt != 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic test_operators();
        send_text("(){}[],;:?.~ + ++ += - -- -= -> * *= / /= % %= & && &= | || |= ");
        send_text("^ ^= ! != = == < << <<= <= > >> >>= >= a<<b>>");
        send_end();
    endtask

    task automatic test_numbers();
        send_text("0 0x1F 0XaB 0b101 0B2 123uL 1.5 9223372036854775808 0x ");
        send_text("0xFFFFFFFFFFFFFFFFF 3.14.1 00 7");
        send_end();
    endtask

    task automatic test_words();
        send_text("if char short sizeof _x9 abcdefghi unsigned voidx I64\n");
        send_text("volatile Bool goto_");
        send_end();
    endtask

    task automatic test_literals();
        send_text("\"a\\n\\t\\r\\0\\q\\\"\" 'x' '\\'' \"open\\");
        send_end();
        send_text("'z");
        send_end();
    endtask

    task automatic test_comments();
        send_text("// line ( \n/* ** / */x/*/ open");
        send_end();
    endtask

    task automatic test_limits();
        for (int i = 0; i < 64; i++) send_item(WORD_CHARS[$urandom_range(1, 52)], 1'b0);
        send_item(" ", 1'b0);
        for (int i = 0; i < 64; i++) send_item("9", 1'b0);
        send_text(" \"");
        for (int i = 0; i < 255; i++) send_item(8'($urandom_range(1, 255)) | 8'h80, 1'b0);
        send_item(" ", 1'b0);
        send_end();
    endtask

    task automatic send_fragment();
        int n;
        logic [7:0] b;
        case ($urandom_range(0, 11))
            0: begin
                n = $urandom_range(1, 3);
                repeat (n) send_item(OP_CHARS[$urandom_range(0, OP_CHARS.len() - 1)], 1'b0);
            end
            1: begin
                send_item(WORD_CHARS[$urandom_range(0, 52)], 1'b0);
                n = $urandom_range(0, 9);
                repeat (n) send_item(WORD_CHARS[$urandom_range(0, WORD_CHARS.len() - 1)], 1'b0);
            end
            2: send_text(kw_text[$urandom_range(0, 48)]);
            3: begin
                n = $urandom_range(1, 21);
                repeat (n) send_item(8'("0" + $urandom_range(0, 9)), 1'b0);
                if ($urandom_range(0, 1)) send_text("uL");
            end
            4: begin
                send_text($urandom_range(0, 1) ? "0x" : "0X");
                n = $urandom_range(1, 17);
                repeat (n) send_item(HEX_CHARS[$urandom_range(0, HEX_CHARS.len() - 1)], 1'b0);
            end
            5: begin
                send_text($urandom_range(0, 1) ? "0b" : "0B");
                n = $urandom_range(1, 66);
                repeat (n) send_item(8'("0" + $urandom_range(0, 1)), 1'b0);
            end
            6: begin
                n = $urandom_range(1, 4);
                repeat (n) send_item(8'("0" + $urandom_range(0, 9)), 1'b0);
                send_item(".", 1'b0);
                n = $urandom_range(0, 4);
                repeat (n) send_item(8'("0" + $urandom_range(0, 9)), 1'b0);
            end
            7, 8: begin
                send_item($urandom_range(0, 1) ? 8'h22 : 8'h27, 1'b0);
                n = $urandom_range(0, 8);
                repeat (n) begin
                    if ($urandom_range(0, 3) == 0) begin
                        send_item("\\", 1'b0);
                        send_item(ESC_CHARS[$urandom_range(0, 7)], 1'b0);
                    end else begin
                        b = 8'($urandom);
                        if (b == 8'h22 || b == 8'h27 || b == "\\") b = "s";
                        send_item(b, 1'b0);
                    end
                end
                if ($urandom_range(0, 5) != 0) send_item($urandom_range(0, 1) ? 8'h22 : 8'h27,
                                                         1'b0);
            end
            9: begin
                send_text($urandom_range(0, 1) ? "//" : "/*");
                n = $urandom_range(0, 6);
                repeat (n) send_item(8'($urandom), 1'b0);
                send_text($urandom_range(0, 1) ? "\n" : "*/");
            end
            10: send_item(SPACE_CHARS[$urandom_range(0, 3)], 1'b0);
            default: if ($urandom_range(0, 2) == 0) send_end();
        endcase
        if ($urandom_range(0, 1)) send_item(GAP_CHARS[$urandom_range(0, 1)], 1'b0);
    endtask

    task automatic test_random();
        int first;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS) begin
            if ($urandom_range(0, 15) == 0) steady_send = !steady_send;
            send_fragment();
        end
        steady_send = 1'b0;
        send_end();
    endtask

    task automatic test_error();
        send_text("a+");
        send_item(8'h80, 1'b0);
        send_item(8'hFF, 1'b0);
        send_text("x1 ");
        send_end();
        send_item(8'h00, 1'b0);
        send_end();
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item <= '0;
        mismatches = 0;
        idle_cycles = 0;
        items_sent = 0;
        steady_send = 1'b0;
        steady_recv = 1'b0;
        mode = SC_IDLE;
        pend = '0;
        word = "";
        tlen = 0;
        acc = '0;
        radix = R_DEC;
        float_seen = 1'b0;
        single_q = 1'b0;
        escaped = 1'b0;
        line = 1;
        col = 16'd1;
        tline = '0;
        tcol = '0;
        err_seen = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_operators();
        test_numbers();
        test_words();
        test_literals();
        test_comments();
        test_limits();
        test_random();
        test_error();
        i_in_valid <= 1'b0;
        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && tokens_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> c_like_source_tokenizer_core.f
sv/cltok_pkg.sv
sv/cltok_step.sv
sv/c_like_source_tokenizer_core.sv
sim/c_like_source_tokenizer_core_test.sv
